FILE: src/pcc_pkg.sv
// ---------------------------------------------------------------------------
// pcc_pkg: shared types and constants of the polygon convexity check
// Vertex count codes, triple indexes and the bound on results in flight.
// ---------------------------------------------------------------------------
package pcc_pkg;

    // Saturating vertex count
    typedef logic [1:0] t_count;

    localparam t_count CNT_ZERO = 2'd0;
    localparam t_count CNT_ONE  = 2'd1;
    localparam t_count CNT_TWO  = 2'd2;
    localparam t_count CNT_FULL = 2'd3;

    // Triples evaluated per vertex: the running triple and the two closing ones
    localparam int unsigned NUM_TRI    = 3;
    localparam int unsigned TRI_RUN    = 0;
    localparam int unsigned TRI_WRAP_A = 1;
    localparam int unsigned TRI_WRAP_B = 2;

    // Results that can be in flight at once: two pipeline stages and the
    // output register
    typedef logic [1:0] t_pending;
    localparam t_pending MAX_PENDING = 2'd3;

endpackage

FILE: src/polygon_convexity_check.sv
// ---------------------------------------------------------------------------
// polygon_convexity_check: streaming convexity test of a closed polygon
// Vertices in, one convex flag out per polygon, one vertex per cycle unless the output stalls.
// ---------------------------------------------------------------------------
// Feed the vertices of a polygon one transaction at a time on i_x_coord /
// i_y_coord and mark the final vertex with i_last. One transaction on the
// output follows each final vertex, carrying o_convex = 1 unless both a
// clockwise and an anticlockwise turn were found among all consecutive
// vertex triples, the two wrap-around triples included; polygons of fewer
// than three vertices and collinear triples count as convex. Cross products
// are exact (no overflow), so the sign is always the true sign. The block
// takes a new vertex every cycle unless a stalled output backs up: the
// first stage forms the coordinate differences of up to three triples,
// the second holds the six products (two multipliers of COORD_BITS+1
// bits per triple, all three triples in parallel), and the third takes
// the signs, folds them into the sticky turn flags and loads the output
// register. A final vertex's result goes through the stage 1, stage 2
// and output registers to o_valid; with o_valid held against i_ready low,
// up to two further polygons can still be closed before o_ready drops.
// ---------------------------------------------------------------------------
module polygon_convexity_check #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // vertex channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_x_coord,
    input  logic signed [COORD_BITS-1:0] i_y_coord,
    input  logic                         i_last,
    // result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_convex
);

    localparam int unsigned DW = COORD_BITS + 1;   // difference width
    localparam int unsigned PW = 2 * DW;           // product width
    localparam int unsigned SW = PW + 1;           // cross product width
    localparam int unsigned NT = pcc_pkg::NUM_TRI;

    // -----------------------------------------------------------------------
    // Handshake and stage advance
    // -----------------------------------------------------------------------
    logic                  r_v1, r_v2, r_l1, r_l2;
    logic [NT-1:0]         r_m1, r_m2;
    logic                  r_o_valid, r_o_convex;
    logic                  out_free, adv2, free2, adv1, in_acc;

    assign out_free = !r_o_valid || i_ready;
    // a vertex that closes no polygon retires without touching the output
    assign adv2     = r_v2 && (!r_l2 || out_free);
    assign free2    = !r_v2 || adv2;
    assign adv1     = r_v1 && free2;
    assign o_ready  = !r_v1 || adv1;
    assign in_acc   = i_valid && o_ready;

    assign o_valid  = r_o_valid;
    assign o_convex = r_o_convex;

    // -----------------------------------------------------------------------
    // Vertex history
    // -----------------------------------------------------------------------
    pcc_pkg::t_count              r_seen_count;
    logic signed [COORD_BITS-1:0] r_first_x, r_first_y, r_second_x, r_second_y;
    logic signed [COORD_BITS-1:0] r_older_x, r_older_y, r_newer_x, r_newer_y;
    logic                         have_two;

    assign have_two = (r_seen_count == pcc_pkg::CNT_TWO) ||
                      (r_seen_count == pcc_pkg::CNT_FULL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_count <= pcc_pkg::CNT_ZERO;
        end else if (in_acc) begin
            if (i_last) begin
                r_seen_count <= pcc_pkg::CNT_ZERO;
            end else if (r_seen_count != pcc_pkg::CNT_FULL) begin
                r_seen_count <= r_seen_count + pcc_pkg::t_count'(1);
            end
        end
    end

    // Coordinates are only read once the count says they were written
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (r_seen_count == pcc_pkg::CNT_ZERO) begin
                r_first_x <= i_x_coord;
                r_first_y <= i_y_coord;
            end
            if (r_seen_count == pcc_pkg::CNT_ONE) begin
                r_second_x <= i_x_coord;
                r_second_y <= i_y_coord;
            end
            r_older_x <= r_newer_x;
            r_older_y <= r_newer_y;
            r_newer_x <= i_x_coord;
            r_newer_y <= i_y_coord;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 1: differences of each triple (a - b) and (c - b)
    // -----------------------------------------------------------------------
    logic signed [DW-1:0] ax [NT], ay [NT], bx [NT], by [NT], cx [NT], cy [NT];
    logic signed [DW-1:0] r_d1x [NT], r_d1y [NT], r_d2x [NT], r_d2y [NT];
    logic [NT-1:0]        n_m1;

    always_comb begin
        // running triple: two previous vertices and the new one
        ax[pcc_pkg::TRI_RUN]    = DW'(r_older_x);
        ay[pcc_pkg::TRI_RUN]    = DW'(r_older_y);
        bx[pcc_pkg::TRI_RUN]    = DW'(r_newer_x);
        by[pcc_pkg::TRI_RUN]    = DW'(r_newer_y);
        cx[pcc_pkg::TRI_RUN]    = DW'(i_x_coord);
        cy[pcc_pkg::TRI_RUN]    = DW'(i_y_coord);
        // closing triple around the final vertex
        ax[pcc_pkg::TRI_WRAP_A] = DW'(r_newer_x);
        ay[pcc_pkg::TRI_WRAP_A] = DW'(r_newer_y);
        bx[pcc_pkg::TRI_WRAP_A] = DW'(i_x_coord);
        by[pcc_pkg::TRI_WRAP_A] = DW'(i_y_coord);
        cx[pcc_pkg::TRI_WRAP_A] = DW'(r_first_x);
        cy[pcc_pkg::TRI_WRAP_A] = DW'(r_first_y);
        // closing triple around the first vertex
        ax[pcc_pkg::TRI_WRAP_B] = DW'(i_x_coord);
        ay[pcc_pkg::TRI_WRAP_B] = DW'(i_y_coord);
        bx[pcc_pkg::TRI_WRAP_B] = DW'(r_first_x);
        by[pcc_pkg::TRI_WRAP_B] = DW'(r_first_y);
        cx[pcc_pkg::TRI_WRAP_B] = DW'(r_second_x);
        cy[pcc_pkg::TRI_WRAP_B] = DW'(r_second_y);

        n_m1                         = '0;
        n_m1[pcc_pkg::TRI_RUN]       = have_two;
        n_m1[pcc_pkg::TRI_WRAP_A]    = have_two && i_last;
        n_m1[pcc_pkg::TRI_WRAP_B]    = have_two && i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_l1 <= i_last;
            r_m1 <= n_m1;
            for (int k = 0; k < NT; k++) begin
                r_d1x[k] <= ax[k] - bx[k];
                r_d1y[k] <= ay[k] - by[k];
                r_d2x[k] <= cx[k] - bx[k];
                r_d2y[k] <= cy[k] - by[k];
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stage 2: the two products of each cross product
    // -----------------------------------------------------------------------
    logic signed [PW-1:0] r_pa [NT], r_pb [NT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (free2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_l2 <= r_l1;
            r_m2 <= r_m1;
            for (int k = 0; k < NT; k++) begin
                r_pa[k] <= PW'(r_d1x[k]) * PW'(r_d2y[k]);
                r_pb[k] <= PW'(r_d1y[k]) * PW'(r_d2x[k]);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stage 3: signs, sticky turn flags and the result
    // -----------------------------------------------------------------------
    logic signed [SW-1:0] xprod [NT];
    logic [NT-1:0]        tri_neg, tri_pos;
    logic                 r_seen_negative, r_seen_positive;
    logic                 n_seen_negative, n_seen_positive;

    always_comb begin
        for (int k = 0; k < NT; k++) begin
            xprod[k]   = SW'(r_pa[k]) - SW'(r_pb[k]);
            tri_neg[k] = r_m2[k] && xprod[k][SW-1];
            tri_pos[k] = r_m2[k] && !xprod[k][SW-1] && (xprod[k] != '0);
        end
        n_seen_negative = r_seen_negative || (|tri_neg);
        n_seen_positive = r_seen_positive || (|tri_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_negative <= 1'b0;
            r_seen_positive <= 1'b0;
        end else if (adv2) begin
            // clear on the final vertex so the next polygon starts fresh
            r_seen_negative <= n_seen_negative && !r_l2;
            r_seen_positive <= n_seen_positive && !r_l2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv2 && r_l2) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_l2) begin
            r_o_convex <= !(n_seen_negative && n_seen_positive);
        end
    end

endmodule

FILE: src/pcc_checker.sv
// ---------------------------------------------------------------------------
// pcc_checker: port-level checks of the polygon convexity check
// Tracks polygons closed but not yet reported and checks the result channel.
// ---------------------------------------------------------------------------
module pcc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic i_last,
    input logic o_valid,
    input logic i_ready,
    input logic o_convex
);

    pcc_pkg::t_pending r_pending;
    logic              closed, reported;

    assign closed   = i_valid && o_ready && i_last;
    assign reported = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + pcc_pkg::t_pending'(closed)
                                   - pcc_pkg::t_pending'(reported);
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_convex))
        else $error("result dropped or changed while stalled");

    // every result belongs to a polygon already closed
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pending != '0)
        else $error("result without a closed polygon");

    // with every stage holding a closed polygon and the output stalled,
    // no further vertex is taken
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == pcc_pkg::MAX_PENDING) && !i_ready |-> !o_ready)
        else $error("vertex taken with all result slots full");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind polygon_convexity_check pcc_checker u_pcc_checker (.*);
